// ----- hw/rtl/idp_pkg.sv -----
// ----------------------------------------------------------------------------
// idp_pkg: shared definitions for the ISO 8601 duration parser
// Designator ranks, unit scaling constants and the record handed from the
// character front end to the arithmetic back end.
// ----------------------------------------------------------------------------
package idp_pkg;

    // Default width of the decimal number accumulator.
    localparam int NUMBER_BITS_DEFAULT = 32;

    // Width of one slice of the number that feeds one multiplier.
    localparam int CHUNK_BITS = 24;

    // Width of the largest unit in milliseconds (one year).
    localparam int UNIT_BITS = 35;

    // Width of the result total and of the fraction contribution.
    localparam int TOTAL_BITS = 63;
    localparam int FRAC_BITS  = 10;

    // Designator ranks in the order the standard allows them.
    localparam logic [2:0] RANK_NONE   = 3'd0;
    localparam logic [2:0] RANK_YEAR   = 3'd1;
    localparam logic [2:0] RANK_MONTH  = 3'd2;
    localparam logic [2:0] RANK_WEEK   = 3'd3;
    localparam logic [2:0] RANK_DAY    = 3'd4;
    localparam logic [2:0] RANK_HOUR   = 3'd5;
    localparam logic [2:0] RANK_MINUTE = 3'd6;
    localparam logic [2:0] RANK_SECOND = 3'd7;

    // Unit scaling: nominal hours per calendar unit and milliseconds per time unit.
    localparam logic [63:0] HOURS_PER_YEAR  = 64'd8760;
    localparam logic [63:0] HOURS_PER_MONTH = 64'd720;
    localparam logic [63:0] HOURS_PER_WEEK  = 64'd168;
    localparam logic [63:0] HOURS_PER_DAY   = 64'd24;
    localparam logic [63:0] MS_PER_SECOND   = 64'd1000;
    localparam logic [63:0] MS_PER_MINUTE   = 64'd60 * MS_PER_SECOND;
    localparam logic [63:0] MS_PER_HOUR     = 64'd60 * MS_PER_MINUTE;

    // Record passed through the queue alongside the number.
    typedef struct packed {
        logic                 is_end;    // final character of the string
        logic                 syntax;    // string rejected
        logic                 num_ovf;   // number accumulator saturated
        logic [2:0]           rank;      // designator taken, or none
        logic [FRAC_BITS-1:0] frac_val;  // fraction of a second in ms
    } idp_ctl_t;

    // Milliseconds per unit, indexed by rank.
    function automatic logic [UNIT_BITS-1:0] unit_ms(input logic [2:0] rank);
        logic [63:0] v;
        begin
            case (rank)
                RANK_YEAR:   v = HOURS_PER_YEAR * MS_PER_HOUR;
                RANK_MONTH:  v = HOURS_PER_MONTH * MS_PER_HOUR;
                RANK_WEEK:   v = HOURS_PER_WEEK * MS_PER_HOUR;
                RANK_DAY:    v = HOURS_PER_DAY * MS_PER_HOUR;
                RANK_HOUR:   v = MS_PER_HOUR;
                RANK_MINUTE: v = MS_PER_MINUTE;
                RANK_SECOND: v = MS_PER_SECOND;
                default:     v = 64'd0;
            endcase
            return v[UNIT_BITS-1:0];
        end
    endfunction

endpackage

// ----- hw/rtl/idp_front.sv -----
// ----------------------------------------------------------------------------
// idp_front: character front end
// Classifies each character, tracks the parse phase, builds the decimal
// number and the fraction, and emits one record per designator or end.
// ----------------------------------------------------------------------------
module idp_front #(
    parameter int NUMBER_BITS = idp_pkg::NUMBER_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  logic [7:0]             char_code,
    input  logic                   last_char,
    output logic                   push,
    output idp_pkg::idp_ctl_t      push_ctl,
    output logic [NUMBER_BITS-1:0] push_number
);

    localparam logic [1:0] PH_EXPECT_P = 2'd0;
    localparam logic [1:0] PH_DATE     = 2'd1;
    localparam logic [1:0] PH_TIME     = 2'd2;
    localparam logic [1:0] PH_ERROR    = 2'd3;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam int FB = idp_pkg::FRAC_BITS;

    logic [1:0]             phase_reg,      phase_next;
    logic [NUMBER_BITS-1:0] acc_reg,        acc_next;
    logic                   digits_reg,     digits_next;
    logic [FB-1:0]          frac_reg,       frac_next;
    logic [1:0]             frac_cnt_reg,   frac_cnt_next;
    logic                   in_frac_reg,    in_frac_next;
    logic [2:0]             last_rank_reg,  last_rank_next;
    logic                   ovf_reg,        ovf_next;

    logic                   is_digit;
    logic [3:0]             digit;
    logic [NUMBER_BITS+3:0] acc_wide;
    logic [FB+3:0]          frac_wide;
    logic [2:0]             rank;
    logic                   take_term;
    logic                   fin_err;
    logic [6:0]             scale;
    logic [FB+6:0]          frac_prod;

    assign is_digit  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign digit     = 4'(char_code - CH_ZERO);
    assign acc_wide  = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0} + (NUMBER_BITS + 4)'(digit);
    assign frac_wide = {frac_reg, 3'b000} + {2'b00, frac_reg, 1'b0} + (FB + 4)'(digit);

    // Designator rank within the current part of the text.
    always_comb begin
        rank = idp_pkg::RANK_NONE;
        if (phase_reg == PH_DATE) begin
            case (char_code)
                CH_Y:    rank = idp_pkg::RANK_YEAR;
                CH_M:    rank = idp_pkg::RANK_MONTH;
                CH_W:    rank = idp_pkg::RANK_WEEK;
                CH_D:    rank = idp_pkg::RANK_DAY;
                default: rank = idp_pkg::RANK_NONE;
            endcase
        end else if (phase_reg == PH_TIME) begin
            case (char_code)
                CH_H:    rank = idp_pkg::RANK_HOUR;
                CH_M:    rank = idp_pkg::RANK_MINUTE;
                CH_S:    rank = idp_pkg::RANK_SECOND;
                default: rank = idp_pkg::RANK_NONE;
            endcase
        end
    end

    // Weight of the fraction digits collected so far.
    always_comb begin
        case (frac_cnt_reg)
            2'd1:    scale = 7'd100;
            2'd2:    scale = 7'd10;
            2'd3:    scale = 7'd1;
            default: scale = 7'd0;
        endcase
    end

    assign frac_prod = frac_reg * scale;

    // Parse step for one character.
    always_comb begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        digits_next    = digits_reg;
        frac_next      = frac_reg;
        frac_cnt_next  = frac_cnt_reg;
        in_frac_next   = in_frac_reg;
        last_rank_next = last_rank_reg;
        ovf_next       = ovf_reg;
        take_term      = 1'b0;

        if (phase_reg == PH_ERROR) begin
            phase_next = PH_ERROR;
        end else if (phase_reg == PH_EXPECT_P) begin
            phase_next = (char_code == CH_P) ? PH_DATE : PH_ERROR;
        end else if (is_digit) begin
            if (in_frac_reg) begin
                if (frac_cnt_reg != 2'd3) begin
                    frac_next     = frac_wide[FB-1:0];
                    frac_cnt_next = frac_cnt_reg + 2'd1;
                end
            end else begin
                if (acc_wide[NUMBER_BITS+3:NUMBER_BITS] != 4'd0) begin
                    acc_next = '1;
                    ovf_next = 1'b1;
                end else begin
                    acc_next = acc_wide[NUMBER_BITS-1:0];
                end
                digits_next = 1'b1;
            end
        end else if ((char_code == CH_DOT) || (char_code == CH_COMMA)) begin
            if ((phase_reg == PH_TIME) && digits_reg && !in_frac_reg) begin
                in_frac_next = 1'b1;
            end else begin
                phase_next = PH_ERROR;
            end
        end else if (char_code == CH_T) begin
            if ((phase_reg == PH_DATE) && !digits_reg) begin
                phase_next = PH_TIME;
            end else begin
                phase_next = PH_ERROR;
            end
        end else if ((rank == idp_pkg::RANK_NONE) || !digits_reg ||
                     (rank <= last_rank_reg) ||
                     (in_frac_reg && ((rank != idp_pkg::RANK_SECOND) ||
                                      (frac_cnt_reg == 2'd0)))) begin
            phase_next = PH_ERROR;
        end else begin
            take_term      = 1'b1;
            acc_next       = '0;
            digits_next    = 1'b0;
            in_frac_next   = 1'b0;
            frac_next      = '0;
            frac_cnt_next  = 2'd0;
            last_rank_next = rank;
        end
    end

    // Checks on the text as a whole once the final character is in.
    assign fin_err = (phase_next == PH_EXPECT_P) || digits_next || in_frac_next ||
                     (last_rank_next == idp_pkg::RANK_NONE) ||
                     ((phase_next == PH_TIME) && (last_rank_next < idp_pkg::RANK_HOUR));

    // Record for the back end.
    always_comb begin
        push              = accept && (take_term || last_char);
        push_number       = take_term ? acc_reg : '0;
        push_ctl.is_end   = last_char;
        push_ctl.syntax   = (phase_next == PH_ERROR) || fin_err;
        push_ctl.num_ovf  = ovf_next;
        push_ctl.rank     = take_term ? rank : idp_pkg::RANK_NONE;
        push_ctl.frac_val = (take_term && in_frac_reg) ? frac_prod[FB-1:0] : '0;
    end

    // Parse state; the final character returns everything to the start.
    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && last_char)) begin
            phase_reg     <= PH_EXPECT_P;
            acc_reg       <= '0;
            digits_reg    <= 1'b0;
            frac_reg      <= '0;
            frac_cnt_reg  <= 2'd0;
            in_frac_reg   <= 1'b0;
            last_rank_reg <= idp_pkg::RANK_NONE;
            ovf_reg       <= 1'b0;
        end else if (accept) begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            digits_reg    <= digits_next;
            frac_reg      <= frac_next;
            frac_cnt_reg  <= frac_cnt_next;
            in_frac_reg   <= in_frac_next;
            last_rank_reg <= last_rank_next;
            ovf_reg       <= ovf_next;
        end
    end

endmodule

// ----- hw/rtl/idp_fifo.sv -----
// ----------------------------------------------------------------------------
// idp_fifo: four-entry queue between front end and back end
// Holds parse records so that either side may stall without the other.
// ----------------------------------------------------------------------------
module idp_fifo #(
    parameter int WIDTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty,
    output logic             full
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == (AW + 1)'(DEPTH));
    assign rd_data = mem_reg[rd_ptr_reg];

    // Storage.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (wr_en && !rd_en) begin
                count_reg <= count_reg + (AW + 1)'(1);
            end else if (!wr_en && rd_en) begin
                count_reg <= count_reg - (AW + 1)'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/idp_back.sv -----
// ----------------------------------------------------------------------------
// idp_back: arithmetic back end
// Scales each number by its unit in sliced multipliers, adds the fraction,
// accumulates the saturating total and presents the result beat.
// ----------------------------------------------------------------------------
module idp_back #(
    parameter int NUMBER_BITS = idp_pkg::NUMBER_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   q_empty,
    input  idp_pkg::idp_ctl_t      q_ctl,
    input  logic [NUMBER_BITS-1:0] q_number,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [71:0]            m_tdata
);

    localparam int CB      = idp_pkg::CHUNK_BITS;
    localparam int UB      = idp_pkg::UNIT_BITS;
    localparam int TB      = idp_pkg::TOTAL_BITS;
    localparam int CHUNKS  = (NUMBER_BITS + CB - 1) / CB;
    localparam int PAD_W   = CHUNKS * CB;
    localparam int PROD_W  = CB + UB;
    localparam int RAW_W   = PAD_W + UB + 1;
    localparam int SUM_W   = (RAW_W > TB + 1) ? RAW_W : TB + 1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SYNTAX   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    logic [PAD_W-1:0]  num_pad;
    logic [UB-1:0]     unit;
    logic              stall;

    logic              a_valid_reg;
    idp_pkg::idp_ctl_t a_ctl_reg;
    logic [PROD_W-1:0] a_prod_reg [CHUNKS];

    logic              b_valid_reg;
    idp_pkg::idp_ctl_t b_ctl_reg;
    logic [TB-1:0]     b_part_reg;
    logic              b_sat_reg;

    logic [TB-1:0]     total_reg;
    logic              ovf_reg;
    logic              out_valid_reg;
    logic [TB-1:0]     out_ms_reg;
    logic [1:0]        out_status_reg;

    logic [SUM_W-1:0]  part_sum;
    logic              part_sat;
    logic [TB:0]       tot_sum;
    logic              tot_sat;
    logic [TB-1:0]     tot_new;
    logic              out_load;

    assign num_pad = PAD_W'(q_number);
    assign unit    = idp_pkg::unit_ms(q_ctl.rank);

    // The pipe holds only when a finished result has nowhere to go.
    assign out_load = !out_valid_reg || m_tready;
    assign stall    = b_valid_reg && b_ctl_reg.is_end && !out_load;
    assign q_pop    = !q_empty && !stall;

    // Stage A: one multiplier per slice of the number.
    for (genvar k = 0; k < CHUNKS; k++) begin : g_mul
        always_ff @(posedge aclk) begin
            if (!stall) begin
                a_prod_reg[k] <= num_pad[k*CB +: CB] * unit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            a_ctl_reg <= q_ctl;
        end
    end

    // Stage B: recombine the slices, add the fraction, saturate.
    always_comb begin
        part_sum = SUM_W'(a_ctl_reg.frac_val);
        for (int k = 0; k < CHUNKS; k++) begin
            part_sum = part_sum + (SUM_W'(a_prod_reg[k]) << (k * CB));
        end
        part_sat = (part_sum[SUM_W-1:TB] != '0);
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            b_ctl_reg  <= a_ctl_reg;
            b_part_reg <= part_sat ? '1 : part_sum[TB-1:0];
            b_sat_reg  <= part_sat;
        end
    end

    // Stage C: saturating running total.
    assign tot_sum = {1'b0, total_reg} + {1'b0, b_part_reg};
    assign tot_sat = tot_sum[TB];
    assign tot_new = tot_sat ? '1 : tot_sum[TB-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            total_reg   <= '0;
            ovf_reg     <= 1'b0;
        end else if (!stall) begin
            a_valid_reg <= q_pop;
            b_valid_reg <= a_valid_reg;
            if (b_valid_reg) begin
                if (b_ctl_reg.is_end) begin
                    total_reg <= '0;
                    ovf_reg   <= 1'b0;
                end else begin
                    total_reg <= tot_new;
                    ovf_reg   <= ovf_reg || b_sat_reg || tot_sat;
                end
            end
        end
    end

    // Result beat register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (b_valid_reg && b_ctl_reg.is_end && out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_valid_reg && b_ctl_reg.is_end && out_load) begin
            if (b_ctl_reg.syntax) begin
                out_ms_reg     <= '0;
                out_status_reg <= ST_SYNTAX;
            end else begin
                out_ms_reg     <= tot_new;
                out_status_reg <= (b_ctl_reg.num_ovf || ovf_reg || b_sat_reg || tot_sat) ?
                                  ST_OVERFLOW : ST_OK;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_status_reg, out_ms_reg};

endmodule

// ----- hw/rtl/iso8601_duration_parser.sv -----
// ----------------------------------------------------------------------------
// iso8601_duration_parser: ISO 8601 duration to milliseconds
// Takes the duration text one character per beat and returns the total in
// milliseconds with a status on the final character.
// ----------------------------------------------------------------------------
// The block accepts one character every cycle for as long as its four-entry
// record queue has room; the front end parses each character combinationally.
// Years, months, weeks and days count as 8760, 720, 168 and 24 hours; a
// fraction is allowed on seconds only and is truncated to whole milliseconds.
// The result beat (status 0 ok, 1 syntax error with a zero duration, 2
// saturated overflow) follows the final character through the queue, the
// sliced unit multipliers, the recombine and saturate stage and the result
// register, which takes the running total with the last term added. A held
// result stalls the back end only; characters keep flowing until the queue fills.
// ----------------------------------------------------------------------------
module iso8601_duration_parser #(
    parameter int NUMBER_BITS = idp_pkg::NUMBER_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // last_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [62:0] duration_ms, [64:63] status, rest zero
);

    localparam int CTL_W = $bits(idp_pkg::idp_ctl_t);
    localparam int REC_W = CTL_W + NUMBER_BITS;

    logic                   accept;
    logic                   push;
    idp_pkg::idp_ctl_t      push_ctl;
    logic [NUMBER_BITS-1:0] push_number;
    logic [REC_W-1:0]       q_data;
    logic                   q_empty;
    logic                   q_full;
    logic                   q_pop;
    idp_pkg::idp_ctl_t      q_ctl;
    logic [NUMBER_BITS-1:0] q_number;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign q_ctl    = q_data[CTL_W-1:0];
    assign q_number = q_data[REC_W-1:CTL_W];

    idp_front #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .char_code   (s_tdata),
        .last_char   (s_tlast),
        .push        (push),
        .push_ctl    (push_ctl),
        .push_number (push_number)
    );

    idp_fifo #(
        .WIDTH (REC_W)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (push),
        .wr_data ({push_number, push_ctl}),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .empty   (q_empty),
        .full    (q_full)
    );

    idp_back #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_ctl    (q_ctl),
        .q_number (q_number),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
